// ===== rtl/linear_probe_hash_table_assert.svh =====
// Assertion macros for the linear probe hash table.
// Used by the controller and the top level; no other dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define LPHT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define LPHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define LPHT_ASSERT(label, clk, rst_n, prop)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/lpht_pkg.sv =====
// Shared constants and types of the linear probe hash table.
// No dependencies.
package lpht_pkg;
	localparam int Capacity   = 16384;
	localparam int SlotBits   = $clog2(Capacity);
	localparam int KeyBytes   = 8;
	localparam int KeyBits    = 8 * KeyBytes;
	localparam int LenBits    = 4;
	localparam int HandleBits = 16;
	localparam int CountBits  = 15;
	localparam int MetaBits   = 1 + LenBits + HandleBits;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_FIND   = 2'd1;
	localparam logic [1:0] FUNC_ERASE  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic             init;
		logic             start;
		logic             hash_step;
		logic             load_home;
		logic             rd;
		logic             adv;
		logic             wr_new;
		logic             wr_clear;
		logic             wr_place;
		logic             take_entry;
		logic             load_nx;
		logic             cnt_inc;
		logic             cnt_dec;
		logic             set_res;
		logic [1:0]       res_status;
		logic             res_found;
	} lpht_cmd_t;

	typedef struct packed {
		logic hash_done;
		logic slot_valid;
		logic slot_match;
		logic wrap;
		logic nx_wrap;
		logic at_limit;
		logic ptr_last;
	} lpht_stat_t;
endpackage

// ===== rtl/lpht_datapath.sv =====
// Datapath of the linear probe hash table: hash unit, slot memories, probe
// pointers and entry counter. Depends on lpht_pkg.
module lpht_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpht_pkg::lpht_cmd_t             cmd,
	output lpht_pkg::lpht_stat_t            stat,
	input  logic [lpht_pkg::KeyBits-1:0]    key_bytes,
	input  logic [lpht_pkg::LenBits-1:0]    key_length,
	input  logic [lpht_pkg::HandleBits-1:0] value_in,
	input  logic [lpht_pkg::CountBits-1:0]  max_entries,
	output logic [1:0]                      status,
	output logic [lpht_pkg::HandleBits-1:0] value_out,
	output logic [lpht_pkg::CountBits-1:0]  entry_count
);
	import lpht_pkg::*;

	logic [KeyBits-1:0]    key_mem [Capacity];
	logic [MetaBits-1:0]   meta_mem [Capacity];
	logic [KeyBits-1:0]    rd_key_q;
	logic [MetaBits-1:0]   rd_meta_q;
	logic [KeyBits-1:0]    key_q;
	logic [LenBits-1:0]    len_q;
	logic [HandleBits-1:0] val_q;
	logic [KeyBits-1:0]    hkey_q;
	logic [LenBits-1:0]    hlen_q;
	logic [LenBits-1:0]    hcnt_q;
	logic [63:0]           hash_q;
	logic [SlotBits-1:0]   home_q;
	logic [SlotBits-1:0]   ptr_q;
	logic [SlotBits-1:0]   at_q;
	logic [SlotBits-1:0]   nx_q;
	logic [CountBits-1:0]  count_q;
	logic [LenBits-1:0]    len_c;
	logic [KeyBits-1:0]    norm_c;
	logic [63:0]           char_c;
	logic [7:0]            byte_c;
	logic [SlotBits-1:0]   ptr_next;
	logic [SlotBits-1:0]   wr_addr;
	logic                  key_we;
	logic                  meta_we;
	logic [MetaBits-1:0]   wr_meta;

	always_comb begin
		len_c = (key_length > LenBits'(KeyBytes)) ? LenBits'(KeyBytes) : key_length;
		for (int i = 0; i < KeyBytes; i++) begin
			norm_c[(KeyBytes-1-i)*8 +: 8] = (LenBits'(i) < len_c) ?
				key_bytes[(KeyBytes-1-i)*8 +: 8] : 8'd0;
		end
	end

	assign byte_c = hkey_q[KeyBits-1 -: 8];
	assign char_c = {{56{byte_c[7]}}, byte_c};
	assign ptr_next = ptr_q + SlotBits'(1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q  <= norm_c;
			len_q  <= len_c;
			val_q  <= value_in;
			hkey_q <= norm_c;
			hlen_q <= len_c;
			hcnt_q <= '0;
			hash_q <= 64'd5381;
		end else if (cmd.take_entry) begin
			key_q  <= rd_key_q;
			len_q  <= rd_meta_q[HandleBits +: LenBits];
			val_q  <= rd_meta_q[HandleBits-1:0];
			hkey_q <= rd_key_q;
			hlen_q <= rd_meta_q[HandleBits +: LenBits];
			hcnt_q <= '0;
			hash_q <= 64'd5381;
		end else if (cmd.hash_step) begin
			hash_q <= (hash_q << 5) + hash_q + char_c;
			hkey_q <= hkey_q << 8;
			hcnt_q <= hcnt_q + LenBits'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q <= '0;
			ptr_q  <= '0;
			at_q   <= '0;
			nx_q   <= '0;
		end else begin
			if (cmd.load_home) begin
				home_q <= hash_q[SlotBits-1:0];
				ptr_q  <= hash_q[SlotBits-1:0];
			end else if (cmd.load_nx) begin
				ptr_q <= nx_q;
			end else if (cmd.adv) begin
				ptr_q <= ptr_next;
			end
			if (cmd.wr_clear) begin
				at_q <= ptr_q;
				nx_q <= ptr_next;
			end else if (cmd.take_entry) begin
				nx_q <= nx_q + SlotBits'(1);
			end
		end
	end

	always_comb begin
		key_we  = cmd.wr_new | cmd.wr_place;
		meta_we = key_we | cmd.wr_clear | cmd.take_entry | cmd.init;
		wr_addr = cmd.take_entry ? nx_q : ptr_q;
		wr_meta = key_we ? {1'b1, len_q, val_q} : '0;
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[ptr_q] <= key_q;
		if (meta_we) meta_mem[wr_addr] <= wr_meta;
		if (cmd.rd) begin
			rd_key_q  <= key_mem[ptr_q];
			rd_meta_q <= meta_mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.cnt_inc) count_q <= count_q + CountBits'(1);
			else if (cmd.cnt_dec && count_q != '0) count_q <= count_q - CountBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			status    <= cmd.res_status;
			value_out <= cmd.res_found ? rd_meta_q[HandleBits-1:0] : '0;
		end
	end

	assign entry_count = count_q;
	assign stat.hash_done  = (hcnt_q == hlen_q);
	assign stat.slot_valid = rd_meta_q[MetaBits-1];
	assign stat.slot_match = rd_meta_q[MetaBits-1]
		&& rd_meta_q[HandleBits +: LenBits] == len_q && rd_key_q == key_q;
	assign stat.wrap       = (ptr_next == home_q);
	assign stat.nx_wrap    = (nx_q == at_q);
	assign stat.at_limit   = (count_q >= max_entries);
	assign stat.ptr_last   = (ptr_q == '1);
endmodule

// ===== rtl/lpht_ctrl.sv =====
// Controller state machine of the linear probe hash table.
// Depends on lpht_pkg and the assertion macro header.
`include "linear_probe_hash_table_assert.svh"
module lpht_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic [1:0]            func,
	input  logic                  res_free,
	output logic                  busy,
	output logic                  res_load,
	output lpht_pkg::lpht_cmd_t   cmd,
	input  lpht_pkg::lpht_stat_t  stat
);
	import lpht_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HASH  = 4'd1;
	localparam logic [3:0] S_HOME  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_NXRD  = 4'd5;
	localparam logic [3:0] S_NXCHK = 4'd6;
	localparam logic [3:0] S_RHASH = 4'd7;
	localparam logic [3:0] S_RHOME = 4'd8;
	localparam logic [3:0] S_RRD   = 4'd9;
	localparam logic [3:0] S_RCHK  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;
	localparam logic [3:0] S_INIT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			func_q  <= FUNC_INSERT;
		end else begin
			state_q <= state_d;
			if (in_fire) func_q <= func;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		res_load = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				cmd.adv  = 1'b1;
				if (stat.ptr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					cmd.start = 1'b1;
					state_d   = S_HASH;
				end
			end
			S_HASH: begin
				if (stat.hash_done) state_d = S_HOME;
				else cmd.hash_step = 1'b1;
			end
			S_HOME: begin
				cmd.load_home = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.set_res = 1'b1;
				state_d     = S_DONE;
				if (stat.slot_match) begin
					case (func_q)
						FUNC_INSERT: cmd.wr_new = 1'b1;
						FUNC_FIND:   cmd.res_found = 1'b1;
						FUNC_ERASE: begin
							cmd.wr_clear = 1'b1;
							cmd.cnt_dec  = 1'b1;
							state_d      = S_NXRD;
						end
						default: cmd.res_status = ST_NOTFOUND;
					endcase
					cmd.load_nx = 1'b0;
				end else if (!stat.slot_valid) begin
					if (func_q == FUNC_INSERT) begin
						if (stat.at_limit) cmd.res_status = ST_FULL;
						else begin
							cmd.wr_new  = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end else cmd.res_status = ST_NOTFOUND;
				end else if (stat.wrap) begin
					cmd.res_status = (func_q == FUNC_INSERT) ? ST_FULL : ST_NOTFOUND;
				end else begin
					cmd.set_res = 1'b0;
					cmd.adv     = 1'b1;
					state_d     = S_RD;
				end
			end
			S_NXRD: begin
				if (stat.nx_wrap) state_d = S_DONE;
				else begin
					cmd.load_nx = 1'b1;
					state_d     = S_NXCHK;
				end
			end
			S_NXCHK: begin
				cmd.rd  = 1'b1;
				state_d = S_RHASH;
			end
			S_RHASH: begin
				if (!stat.slot_valid) state_d = S_DONE;
				else begin
					cmd.take_entry = 1'b1;
					state_d        = S_RHOME;
				end
			end
			S_RHOME: begin
				if (stat.hash_done) begin
					cmd.load_home = 1'b1;
					state_d       = S_RRD;
				end else cmd.hash_step = 1'b1;
			end
			S_RRD: begin
				cmd.rd  = 1'b1;
				state_d = S_RCHK;
			end
			S_RCHK: begin
				if (!stat.slot_valid) begin
					cmd.wr_place = 1'b1;
					state_d      = S_NXRD;
				end else if (stat.wrap) state_d = S_NXRD;
				else begin
					cmd.adv = 1'b1;
					state_d = S_RRD;
				end
			end
			S_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`LPHT_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, in_fire, state_q == S_HASH)
	`LPHT_ASSERT(a_no_fire_busy, clk, arst_n, busy |-> !in_fire)
	`LPHT_ASSERT(a_one_write, clk, arst_n, $onehot0({cmd.wr_new, cmd.wr_clear, cmd.wr_place}))
	`LPHT_ASSERT(a_count_dir, clk, arst_n, !(cmd.cnt_inc && cmd.cnt_dec))
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table; uses lpht_pkg, lpht_ctrl and lpht_datapath.
// Each item first hashes its key byte by byte, then probes slot by slot from its home
// slot; an erase also re-hashes and re-places each later entry of its cluster until an
// empty slot or a wrap ends the cluster. One item at a time; the next is
// accepted once the result sits in the output register, which waits for m_tready.
// Reset sets max_entries to 12288 and clears the count, then clears all 16384 slots.
`include "linear_probe_hash_table_assert.svh"
module linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[1:0], key_bytes[65:2], key_length[69:66], value_in[85:70]
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], value_out[17:2], entry_count[32:18]
	output logic [39:0] m_tdata
);
	import lpht_pkg::*;

	lpht_cmd_t  cmd;
	lpht_stat_t stat;
	logic [CountBits-1:0]  max_q;
	logic                  busy;
	logic                  res_load;
	logic                  in_fire;
	logic [1:0]            status;
	logic [HandleBits-1:0] value_out;
	logic [CountBits-1:0]  entry_count;
	logic                  res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= CountBits'(12288);
		else if (cfg_we) max_q <= cfg_wdata;
	end

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign res_free = !m_tvalid || m_tready;

	lpht_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .func(s_tdata[1:0]), .res_free,
		.busy, .res_load, .cmd, .stat
	);

	lpht_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.key_bytes(s_tdata[65:2]), .key_length(s_tdata[69:66]),
		.value_in(s_tdata[85:70]), .max_entries(max_q),
		.status, .value_out, .entry_count
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (res_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) m_tdata <= {7'd0, entry_count, value_out, status};
	end

	`LPHT_ASSERT_NEXT(a_load_valid, clk, arst_n, res_load, m_tvalid)
	`LPHT_ASSERT(a_load_free, clk, arst_n, res_load |-> res_free)
	`LPHT_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[39:33] == 7'd0)
endmodule

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for the linear probe hash table.
// Drives insert, find, erase and unused-function items with a shadow table as predictor.
// Depends on lpht_pkg and the linear_probe_hash_table top level.
`timescale 1ns / 100ps
module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] value;
		logic [14:0] count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	logic [87:0]   pending_items[$];
	table_result_t expected_results[$];
	logic [63:0]   pool_key[$];
	int            pool_len[$];

	bit          shadow_valid[Capacity];
	logic [63:0] shadow_key[Capacity];
	logic [3:0]  shadow_len[Capacity];
	logic [15:0] shadow_val[Capacity];
	int          shadow_count = 0;
	int          entry_limit = 12288;

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_seen = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cnt = 0;
	bit hold_req = 0;
	bit quiet = 0;

	always #2 clk = ~clk;

	linear_probe_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int home_of(logic [63:0] k, int len);
		logic [63:0] h;
		logic [7:0]  c;
		h = 64'd5381;
		for (int i = 0; i < len; i++) begin
			c = k[(7 - i) * 8 +: 8];
			h = h * 33 + {{56{c[7]}}, c};
		end
		return int'(h % Capacity);
	endfunction

	function automatic int next_of(int i);
		return (i + 1) % Capacity;
	endfunction

	function automatic int locate(logic [63:0] k, int len);
		int home;
		int i;
		home = home_of(k, len);
		i = home;
		while (shadow_valid[i]) begin
			if (shadow_len[i] == len && shadow_key[i] == k)
				return i;
			i = next_of(i);
			if (i == home)
				break;
		end
		return -1;
	endfunction

	function automatic void replace_entry(logic [63:0] k, int len, logic [15:0] v);
		int home;
		int i;
		home = home_of(k, len);
		i = home;
		while (shadow_valid[i]) begin
			i = next_of(i);
			if (i == home)
				return;
		end
		shadow_valid[i] = 1;
		shadow_key[i] = k;
		shadow_len[i] = 4'(len);
		shadow_val[i] = v;
	endfunction

	function automatic logic [1:0] insert_key(logic [63:0] k, int len, logic [15:0] v);
		int home;
		int i;
		home = home_of(k, len);
		i = home;
		while (shadow_valid[i] && !(shadow_len[i] == len && shadow_key[i] == k)) begin
			i = next_of(i);
			if (i == home)
				return ST_FULL;
		end
		if (!shadow_valid[i]) begin
			if (shadow_count >= entry_limit)
				return ST_FULL;
			shadow_count++;
		end
		shadow_valid[i] = 1;
		shadow_key[i] = k;
		shadow_len[i] = 4'(len);
		shadow_val[i] = v;
		return ST_OK;
	endfunction

	function automatic logic [1:0] erase_key(logic [63:0] k, int len);
		int at;
		int nx;
		logic [63:0] mk;
		int ml;
		logic [15:0] mv;
		at = locate(k, len);
		if (at < 0)
			return ST_NOTFOUND;
		shadow_valid[at] = 0;
		if (shadow_count > 0)
			shadow_count--;
		nx = next_of(at);
		while (nx != at && shadow_valid[nx]) begin
			mk = shadow_key[nx];
			ml = int'(shadow_len[nx]);
			mv = shadow_val[nx];
			shadow_valid[nx] = 0;
			replace_entry(mk, ml, mv);
			nx = next_of(nx);
		end
		return ST_OK;
	endfunction

	function automatic table_result_t predict_table(logic [87:0] d);
		table_result_t r;
		logic [1:0]  f;
		logic [63:0] k;
		int          len;
		int          at;
		f = d[1:0];
		len = int'(d[69:66]);
		if (len > KeyBytes)
			len = KeyBytes;
		k = '0;
		for (int i = 0; i < len; i++)
			k[(7 - i) * 8 +: 8] = d[2 + (7 - i) * 8 +: 8];
		r.status = ST_NOTFOUND;
		r.value = '0;
		case (f)
			FUNC_INSERT: r.status = insert_key(k, len, d[85:70]);
			FUNC_FIND: begin
				at = locate(k, len);
				if (at >= 0) begin
					r.status = ST_OK;
					r.value = shadow_val[at];
				end
			end
			FUNC_ERASE: r.status = erase_key(k, len);
			default: r.status = ST_NOTFOUND;
		endcase
		r.count = shadow_count[14:0];
		return r;
	endfunction

	function automatic logic [87:0] make_item(logic [1:0] f, logic [63:0] k, int len,
			logic [15:0] v);
		logic [63:0] kb;
		logic [3:0]  lf;
		kb = {$urandom, $urandom};
		for (int i = 0; i < len; i++)
			kb[(7 - i) * 8 +: 8] = k[(7 - i) * 8 +: 8];
		lf = 4'(len);
		if (len == KeyBytes && $urandom_range(0, 3) == 0)
			lf = 4'($urandom_range(8, 15));
		return {2'b00, v, lf, kb, f};
	endfunction

	function automatic logic [1:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return FUNC_INSERT;
		if (r < 75)
			return FUNC_FIND;
		if (r < 95)
			return FUNC_ERASE;
		return FUNC_UNUSED;
	endfunction

	function automatic void add_item(logic [87:0] d);
		pending_items.insert(pending_items.size(), d);
	endfunction

	function automatic void add_pool(logic [63:0] k, int len);
		pool_key.insert(pool_key.size(), k);
		pool_len.insert(pool_len.size(), len);
	endfunction

	task automatic queue_random(int n);
		int p;
		for (int j = 0; j < n; j++) begin
			p = $urandom_range(0, pool_key.size() - 1);
			add_item(make_item(pick_func(), pool_key[p], pool_len[p],
				16'($urandom_range(0, 65535))));
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		cfg_we <= 1'b1;
		cfg_wdata <= 15'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		entry_limit = v;
		@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.insert(expected_results.size(), predict_table(s_tdata));
				items_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					s_tdata <= pending_items.pop_front();
					s_tvalid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata[1:0] == ST_FULL)
					full_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no item pending: %h", m_tdata);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[1:0] !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, m_tdata[1:0]);
						errors++;
					end
					if (m_tdata[17:2] !== e.value) begin
						$error("value_out: expected %0d, actual %0d", e.value, m_tdata[17:2]);
						errors++;
					end
					if (m_tdata[32:18] !== e.count) begin
						$error("entry_count: expected %0d, actual %0d", e.count,
							m_tdata[32:18]);
						errors++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_cnt = 400;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	initial begin
		logic [63:0] k;
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Two families of length-2 keys that share a home slot, next to each other.
		for (int b = 0; b < 2; b++)
			for (int j = 0; j < 7; j++) begin
				k = '0;
				k[63:56] = 8'(8'h30 + j);
				k[55:48] = 8'(100 + b - 33 * j);
				add_pool(k, 2);
			end
		for (int j = 0; j < 4; j++) begin
			k = '0;
			k[63:56] = 8'(8'h7e + j);
			add_pool(k, 1);
		end
		for (int j = 0; j < 18; j++) begin
			len = $urandom_range(0, 8);
			k = {$urandom, $urandom};
			for (int i = len; i < 8; i++)
				k[(7 - i) * 8 +: 8] = 8'h00;
			add_pool(k, len);
		end

		add_item(make_item(FUNC_INSERT, '0, 0, 16'h1234));
		add_item(make_item(FUNC_INSERT, '1, 8, 16'hffff));
		add_item({2'b00, 16'h0000, 4'hf, 64'h0, FUNC_INSERT});
		add_item(make_item(FUNC_FIND, '0, 0, 16'h0));
		add_item(make_item(FUNC_FIND, '1, 8, 16'h0));
		add_item({2'b00, 16'hffff, 4'h8, 64'h0, FUNC_FIND});
		add_item({2'b00, 16'hffff, 4'hf, 64'hffff_ffff_ffff_ffff, FUNC_UNUSED});
		for (int j = 0; j < 5; j++)
			add_item(make_item(FUNC_INSERT, pool_key[j], 2, 16'(16'h100 + j)));
		add_item(make_item(FUNC_INSERT, pool_key[7], 2, 16'h200));
		add_item(make_item(FUNC_ERASE, pool_key[0], 2, 16'h0));
		for (int j = 1; j < 5; j++)
			add_item(make_item(FUNC_FIND, pool_key[j], 2, 16'h0));
		add_item(make_item(FUNC_INSERT, pool_key[3], 2, 16'hbeef));
		add_item(make_item(FUNC_FIND, pool_key[3], 2, 16'h0));
		add_item(make_item(FUNC_ERASE, pool_key[0], 2, 16'h0));
		add_item(make_item(FUNC_FIND, pool_key[0], 2, 16'h0));
		add_item(make_item(FUNC_ERASE, '1, 8, 16'h0));
		wait_idle();

		write_limit(16384);
		queue_random(400);
		wait_idle();

		write_limit(5);
		queue_random(150);
		wait_idle();

		write_limit(0);
		quiet = 1;
		queue_random(100);
		wait_idle();
		quiet = 0;

		write_limit(1);
		for (int j = 0; j < pool_key.size(); j++)
			add_item(make_item(FUNC_ERASE, pool_key[j], pool_len[j], 16'h0));
		add_item(make_item(FUNC_ERASE, '0, 0, 16'h0));
		add_item(make_item(FUNC_ERASE, '1, 8, 16'h0));
		queue_random(100);
		wait_idle();

		write_limit(12288);
		hold_req = 1;
		queue_random(250);
		wait_idle();

		$display("Sent %0d items and checked %0d results, %0d of them refused as full.",
			items_sent, results_seen, full_seen);
		$display("Limits covered: default, 16384, 5, 0, 1 and 12288.");
		if (errors == 0)
			$display("PASS linear_probe_hash_table");
		else
			$display("FAIL linear_probe_hash_table");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL linear_probe_hash_table");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_datapath.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
